[src/lpc_pkg.sv]
// Shared types, constants and AES helper functions for the payload cipher.
// No dependencies; used by every module of the block.
package lpc_pkg;

   localparam int BLOCK_BYTES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 32;

   localparam logic [1:0] CSR_KEY_HIGH  = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW   = 2'd1;
   localparam logic [1:0] CSR_DIRECTION = 2'd2;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        first_byte;
      logic        last_byte;
      logic [31:0] device_address;
      logic [31:0] frame_counter;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // one classified byte moving from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [3:0] pos;
      logic       new_block;
   } job_type;

   // counter block request to the AES engine
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] counter;
      logic [7:0]  index;
   } blk_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit word sits in bits 127-8i .. 120-8i
   function automatic logic [7:0] byte_of(input logic [127:0] w, input logic [3:0] i);
      return w[8'd127 - {i, 3'b000} -: 8];
   endfunction

   // next round key from the current one and its round constant
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and, unless last, MixColumns
   function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (c * 4 + r) -: 8] = sbox(s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]);
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      return t;
   endfunction

endpackage

[src/lpc_front.sv]
// Front end: accepts requests, tracks byte position and block index,
// issues counter blocks to the AES engine. Depends on lpc_pkg.
module lpc_front #(
   parameter int BLOCK_BYTES = lpc_pkg::BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  lpc_pkg::req_type  req,
   output lpc_pkg::job_type  job,
   output logic              blk_valid,
   output lpc_pkg::blk_type  blk
);
   localparam int PW = $clog2(BLOCK_BYTES);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    index_ff, index_in;
   logic [31:0]   addr_ff, addr_in, cnt_ff, cnt_in;
   logic [PW-1:0] cur_pos;

   always_comb begin
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      index_in = index_ff;
      cur_pos  = pos_ff;
      if (req.first_byte) begin
         addr_in  = req.device_address;
         cnt_in   = req.frame_counter;
         index_in = 8'd1;
         cur_pos  = '0;
      end else if (pos_ff == '0) begin
         index_in = index_ff + 8'd1;
      end
      pos_in = (cur_pos == PW'(BLOCK_BYTES - 1)) ? '0 : cur_pos + PW'(1);
   end

   assign blk_valid     = take && (req.first_byte || pos_ff == '0);
   assign blk.address   = addr_in;
   assign blk.counter   = cnt_in;
   assign blk.index     = index_in;
   assign job.data      = req.payload_byte;
   assign job.last      = req.last_byte;
   assign job.pos       = 4'(cur_pos);
   assign job.new_block = blk_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         index_ff <= '0;
         addr_ff  <= '0;
         cnt_ff   <= '0;
      end else if (take) begin
         pos_ff   <= pos_in;
         index_ff <= index_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

[src/lpc_aes.sv]
// Pipelined AES-128: one round per stage, eleven stages, a block may
// enter every cycle. Round keys are expanded alongside. Depends on lpc_pkg.
module lpc_aes (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [127:0] in_block,
   input  logic [127:0] in_key,
   output logic         out_valid,
   output logic [127:0] out_block
);
   localparam int ROUNDS = 10;
   localparam logic [7:0] RCON [ROUNDS] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                           8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic [ROUNDS:0] vld_ff;
   logic [127:0]    st_ff  [ROUNDS+1];
   logic [127:0]    key_ff [ROUNDS+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[ROUNDS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      st_ff[0]  <= in_block ^ in_key;
      key_ff[0] <= in_key;
      for (int r = 1; r <= ROUNDS; r++) begin
         key_ff[r] <= lpc_pkg::key_step(key_ff[r-1], RCON[r-1]);
         st_ff[r]  <= lpc_pkg::round_fn(st_ff[r-1], r == ROUNDS)
                      ^ lpc_pkg::key_step(key_ff[r-1], RCON[r-1]);
      end
   end

   assign out_valid = vld_ff[ROUNDS];
   assign out_block = st_ff[ROUNDS];
endmodule

[src/lpc_back.sv]
// Back end: job queue, keystream queue and result queue; XORs bytes with
// the matching keystream block. Depends on lpc_pkg.
module lpc_back #(
   parameter int DEPTH = lpc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_push,
   input  lpc_pkg::job_type  job,
   input  logic              ks_valid,
   input  logic [127:0]      ks_block,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output lpc_pkg::rsp_type  rsp
);
   localparam int AW = $clog2(DEPTH);

   // job queue
   lpc_pkg::job_type jq [DEPTH];
   logic [AW:0] jw_ff, jr_ff;
   // keystream queue; an entry is dropped when the first byte of its block uses it
   logic [127:0] kq [DEPTH];
   logic [AW:0] kw_ff, kr_ff;
   logic [127:0] ks_cur_ff;
   // result queue
   lpc_pkg::rsp_type rq [DEPTH];
   logic [AW:0] rw_ff, rr_ff;

   lpc_pkg::job_type head;
   logic jobs_avail, ks_ready, fire, rq_room;
   logic [127:0] ks_use;
   logic [AW:0] in_flight;

   assign head       = jq[jr_ff[AW-1:0]];
   assign jobs_avail = jw_ff != jr_ff;
   assign ks_ready   = !head.new_block || (kw_ff != kr_ff);
   assign rq_room    = (rw_ff - rr_ff) != (AW+1)'(DEPTH);
   assign fire       = jobs_avail && ks_ready && rq_room;
   assign ks_use     = head.new_block ? kq[kr_ff[AW-1:0]] : ks_cur_ff;
   // bound total bytes in flight so neither queue can overflow
   assign in_flight  = (jw_ff - jr_ff) + (rw_ff - rr_ff);
   assign full       = in_flight >= (AW+1)'(DEPTH - 12);
   assign empty      = rw_ff == rr_ff;
   assign rsp        = rq[rr_ff[AW-1:0]];

   always_ff @(posedge clock) begin
      if (job_push) jq[jw_ff[AW-1:0]] <= job;
      if (ks_valid) kq[kw_ff[AW-1:0]] <= ks_block;
      if (fire) begin
         rq[rw_ff[AW-1:0]].out_byte <= head.data ^ lpc_pkg::byte_of(ks_use, head.pos);
         rq[rw_ff[AW-1:0]].out_last <= head.last;
         ks_cur_ff <= ks_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jw_ff <= '0; jr_ff <= '0;
         kw_ff <= '0; kr_ff <= '0;
         rw_ff <= '0; rr_ff <= '0;
      end else begin
         if (job_push) jw_ff <= jw_ff + 1'b1;
         if (ks_valid) kw_ff <= kw_ff + 1'b1;
         if (fire) begin
            jr_ff <= jr_ff + 1'b1;
            rw_ff <= rw_ff + 1'b1;
            if (head.new_block) kr_ff <= kr_ff + 1'b1;
         end
         if (pop && !empty) rr_ff <= rr_ff + 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (jw_ff - jr_ff) <= (AW+1)'(DEPTH)) else $error("job queue overflow");
   a_ks_bound: assert property (@(posedge clock) disable iff (reset)
      (kw_ff - kr_ff) <= (AW+1)'(DEPTH)) else $error("keystream queue overflow");
   a_fire_pops_ks: assert property (@(posedge clock) disable iff (reset)
      fire && head.new_block |=> kr_ff == $past(kr_ff) + 1'b1)
      else $error("keystream not consumed");
endmodule

[src/lorawan_payload_cipher.sv]
// LoRaWAN payload cipher, AES-128 counter mode, top level.
// Depends on lpc_pkg, lpc_front, lpc_aes and lpc_back.
//
// Usage: write key_high (index 0), key_low (1) and direction (2) over the
// csr_ channel while idle; csr_ready is always high. Push payload bytes on
// the req_ queue port whenever req_full is low, one per cycle. Each byte
// gives one result on the rsp_ queue port, in order; pop it while
// rsp_empty is low.
// A byte that opens a keystream block waits for the eleven-stage AES
// pipeline before its result shows as rsp_empty low; other bytes of the
// block follow at one per cycle. Throughput is one byte per cycle while the
// receiver keeps popping, set by the pipelined round unit that takes a new
// counter block every cycle.
// Reset clears all queues and the counters; the key registers clear to 0.
// When the receiver stops popping, results collect in the back queue and
// req_full rises once 20 bytes (queued jobs plus waiting results) are in
// flight.
module lorawan_payload_cipher #(
   parameter int BLOCK_BYTES = lpc_pkg::BLOCK_BYTES_DEF,
   parameter int QUEUE_DEPTH = lpc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lpc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data
);
   logic [63:0] key_high_ff, key_low_ff;
   logic        dir_ff;
   logic        take, blk_valid, ks_valid;
   logic [127:0] ks_block, ctr_block;
   lpc_pkg::job_type job;
   lpc_pkg::blk_type blk;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         dir_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            lpc_pkg::CSR_KEY_HIGH:  key_high_ff <= csr_data;
            lpc_pkg::CSR_KEY_LOW:   key_low_ff  <= csr_data;
            lpc_pkg::CSR_DIRECTION: dir_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign take = req_push && !req_full;
   assign ctr_block = {8'h01, 32'h0, 7'h0, dir_ff,
                       blk.address[7:0], blk.address[15:8],
                       blk.address[23:16], blk.address[31:24],
                       blk.counter[7:0], blk.counter[15:8],
                       blk.counter[23:16], blk.counter[31:24],
                       8'h00, blk.index};

   lpc_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock, .reset, .take, .req(req_data), .job, .blk_valid, .blk);

   lpc_aes u_aes (
      .clock, .reset, .in_valid(blk_valid), .in_block(ctr_block),
      .in_key({key_high_ff, key_low_ff}), .out_valid(ks_valid), .out_block(ks_block));

   lpc_back #(.DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .job_push(take), .job, .ks_valid, .ks_block,
      .full(req_full), .empty(rsp_empty), .pop(rsp_pop), .rsp(rsp_data));
endmodule
